/* sv/srp_pkg.sv */
package srp_pkg;

    localparam int MAX_REPLY = 16;
    localparam int IDX_W     = 5;
    localparam int CPOS_W    = 9;

    localparam logic [IDX_W-1:0] IDX_LAST = '1;

    localparam logic [IDX_W-1:0] POS_TYPE    = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_LEN     = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_POINT   = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_CONTACT = IDX_W'(10);

    localparam logic [7:0] TYPE_STATUS     = 8'd5;
    localparam logic [7:0] TYPE_LONG_PRESS = 8'd3;
    localparam logic [7:0] STATUS_LEN      = 8'd5;
    localparam logic [7:0] POINT_CONTACT   = 8'd1;
    localparam logic [7:0] CONTACT_CLOSED  = 8'd1;
    localparam logic [7:0] CONTACT_OPENED  = 8'd0;

    typedef enum logic [1:0] {
        ST_CLOSED = 2'd0,
        ST_OPENED = 2'd1,
        ST_ERROR  = 2'd2
    } status_t;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed {
        logic       take;
        kind_t      kind;
        logic [7:0] data;
    } step_t;

    typedef struct packed {
        status_t status;
        logic    long_press;
    } result_t;

endpackage

/* sv/srp_frame_tracker.sv */
module srp_frame_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  srp_pkg::step_t  step,
    output srp_pkg::result_t result
);
    import srp_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        pid_reg, pid_next;
    logic [7:0]        cval_reg, cval_next;
    logic              matched_reg, matched_next;
    logic [CPOS_W-1:0] cpos;
    logic [CPOS_W-1:0] pos_wide;
    logic              in_reach;

    assign cpos     = CPOS_W'(6) + CPOS_W'(len_reg);
    assign pos_wide = CPOS_W'(idx_reg);
    assign in_reach = ({1'b0, idx_reg} < (IDX_W+1)'(MAX_REPLY)) && (idx_reg != IDX_LAST);

    always_comb
    begin
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        pid_next     = pid_reg;
        cval_next    = cval_reg;
        matched_next = matched_reg;
        if (step.take)
        begin
            if (step.kind == KIND_BYTE)
            begin
                if (in_reach)
                begin
                    if (idx_reg == POS_TYPE)    type_next = step.data;
                    if (idx_reg == POS_LEN)     len_next  = step.data;
                    if (idx_reg == POS_POINT)   pid_next  = step.data;
                    if (idx_reg == POS_CONTACT) cval_next = step.data;
                    // header bytes always count; later ones only up to the checksum
                    if (idx_reg <= POS_LEN)
                        sum_next = sum_reg + step.data;
                    else if (pos_wide < cpos)
                        sum_next = sum_reg + step.data;
                    else if (pos_wide == cpos)
                        matched_next = (sum_reg == step.data);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            else
            begin
                // drop the frame once its status is out
                idx_next     = '0;
                sum_next     = '0;
                type_next    = '0;
                len_next     = '0;
                pid_next     = '0;
                cval_next    = '0;
                matched_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.status     = ST_ERROR;
        result.long_press = 1'b0;
        if (matched_reg)
        begin
            if (type_reg == TYPE_STATUS && len_reg == STATUS_LEN && pid_reg == POINT_CONTACT)
            begin
                if (cval_reg == CONTACT_CLOSED)
                    result.status = ST_CLOSED;
                else if (cval_reg == CONTACT_OPENED)
                    result.status = ST_OPENED;
            end
            if (type_reg == TYPE_LONG_PRESS)
                result.long_press = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            sum_reg     <= '0;
            type_reg    <= '0;
            len_reg     <= '0;
            pid_reg     <= '0;
            cval_reg    <= '0;
            matched_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
            pid_reg     <= pid_next;
            cval_reg    <= cval_next;
            matched_reg <= matched_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step.take && step.kind == KIND_END |=> idx_reg == '0 && !matched_reg)
        else $error("frame state not cleared after end item");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, idx_reg} <= (IDX_W+1)'(MAX_REPLY))
        else $error("byte index ran past capture limit");

    a_lp_not_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.long_press |-> result.status == ST_ERROR)
        else $error("long press reported with a contact status");

endmodule

/* sv/serial_mcu_reply_status_parser_top.sv */
// Reply status parser: feed the bytes of one serial reply frame (kind 0) and then an
// end item (kind 1); the end item yields one result with contact_status (0 closed,
// 1 opened, 2 error) and long_press, and clears the frame for the next reply. Byte
// items give no result. Each item is registered at the input and then passes the frame
// tracker's update, and an end item's status is written into the output register at the
// same edge as that update. One item can be accepted every cycle while in_stall is low;
// in_stall rises only when an end item waits on a full, stalled output register. Bytes
// beyond the 16-byte capture limit are ignored, and a checksum that lies out of reach,
// or an empty reply, reports error.
module serial_mcu_reply_status_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] contact_status,
    output logic       long_press
);
    import srp_pkg::*;

    logic             s1_valid_reg;
    kind_t            s1_kind_reg;
    logic [7:0]       s1_data_reg;
    logic             s1_advance;
    logic             out_free;
    logic             out_valid_reg;
    result_t          out_res_reg;
    step_t            step;
    result_t          result;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (s1_kind_reg == KIND_BYTE || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;

    assign step.take = s1_advance;
    assign step.kind = s1_kind_reg;
    assign step.data = s1_data_reg;

    srp_frame_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    // hold the input item while it waits for the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_BYTE;
            s1_data_reg  <= '0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
            s1_kind_reg  <= kind_t'(kind);
            s1_data_reg  <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '{status: ST_ERROR, long_press: 1'b0};
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_advance && s1_kind_reg == KIND_END;
            if (s1_advance && s1_kind_reg == KIND_END)
                out_res_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign contact_status = out_res_reg.status;
    assign long_press     = out_res_reg.long_press;

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_kind_reg == KIND_END |=> out_valid_reg)
        else $error("end item consumed without a result");

    a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_kind_reg == KIND_END && out_valid_reg && out_stall |-> in_stall)
        else $error("end item taken while output register is blocked");

    a_byte_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_kind_reg == KIND_BYTE |-> !in_stall)
        else $error("byte item stalled the input");

endmodule

/* tb/reply_status_checker.sv */
`timescale 1ns / 100ps

module reply_status_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] contact_status,
    input  logic       long_press,
    output int         fails,
    output int         pending
);
    import srp_pkg::*;

    // frame state of the predictor
    logic [IDX_W-1:0] frame_pos;
    logic [7:0]       frame_sum;
    logic [7:0]       frame_type;
    logic [7:0]       frame_len;
    logic [7:0]       frame_point;
    logic [7:0]       frame_contact;
    logic             frame_sum_ok;

    result_t status_q[$];
    int      n_err;

    initial
    begin
        n_err = 0;
    end

    task automatic clear_frame();
        frame_pos     = '0;
        frame_sum     = '0;
        frame_type    = '0;
        frame_len     = '0;
        frame_point   = '0;
        frame_contact = '0;
        frame_sum_ok  = 1'b0;
    endtask

    task automatic track_reply_byte(input logic [7:0] b);
        logic [CPOS_W-1:0] sum_pos;
        sum_pos = CPOS_W'(POS_POINT) + CPOS_W'(frame_len);
        // drop bytes beyond the capture limit
        if (frame_pos < MAX_REPLY)
        begin
            if (frame_pos == POS_TYPE)    frame_type    = b;
            if (frame_pos == POS_LEN)     frame_len     = b;
            if (frame_pos == POS_POINT)   frame_point   = b;
            if (frame_pos == POS_CONTACT) frame_contact = b;
            if (frame_pos <= POS_LEN)
                frame_sum = frame_sum + b;
            else if (CPOS_W'(frame_pos) < sum_pos)
                frame_sum = frame_sum + b;
            else if (CPOS_W'(frame_pos) == sum_pos)
                frame_sum_ok = (frame_sum == b);
            frame_pos = frame_pos + IDX_W'(1);
        end
    endtask

    function automatic result_t reply_verdict();
        result_t r;
        r.status     = ST_ERROR;
        r.long_press = 1'b0;
        if (frame_sum_ok)
        begin
            if (frame_type == TYPE_STATUS && frame_len == STATUS_LEN &&
                frame_point == POINT_CONTACT)
            begin
                if (frame_contact == CONTACT_CLOSED)
                    r.status = ST_CLOSED;
                else if (frame_contact == CONTACT_OPENED)
                    r.status = ST_OPENED;
            end
            if (frame_type == TYPE_LONG_PRESS)
                r.long_press = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_frame();
            status_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $error("result with nothing expected: contact_status %0d long_press %0d",
                           contact_status, long_press);
                    n_err++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (contact_status !== want.status)
                    begin
                        $error("contact_status: expected %0d, got %0d",
                               want.status, contact_status);
                        n_err++;
                    end
                    if (long_press !== want.long_press)
                    begin
                        $error("long_press: expected %0d, got %0d",
                               want.long_press, long_press);
                        n_err++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_END)
                begin
                    status_q.push_back(reply_verdict());
                    clear_frame();
                end
                else
                    track_reply_byte(rx_byte);
            end
        end
        fails   <= n_err;
        pending <= status_q.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import srp_pkg::*;

    localparam int ITEM_TARGET = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 90;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    kind_t      kind      = KIND_BYTE;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] contact_status;
    logic       long_press;

    logic quiet   = 1'b0;
    logic hold_go = 1'b0;

    int fails;
    int pending;
    int cycles = 0;
    int sent   = 0;

    logic [7:0] reply_q[$];

    always #6 clk = ~clk;

    serial_mcu_reply_status_parser_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .contact_status (contact_status),
        .long_press     (long_press)
    );

    reply_status_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .contact_status (contact_status),
        .long_press     (long_press),
        .fails          (fails),
        .pending        (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL serial_mcu_reply_status_parser_top");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off once requested
    always @(posedge clk)
    begin
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 21);
    end

    task automatic send_item(input kind_t k, input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_reply();
        for (int n = 0; n < reply_q.size(); n++)
        begin
            send_item(KIND_BYTE, reply_q[n]);
            sent++;
        end
        send_item(KIND_END, 8'($urandom));
        sent++;
    endtask

    // header, payload with point id first and contact value fifth, then checksum
    task automatic make_reply(input logic [7:0] mtype, input logic [7:0] len,
                              input logic [7:0] point, input logic [7:0] contact,
                              input logic [7:0] sum_err);
        logic [7:0] acc;
        reply_q = {8'h55, 8'hAA, 8'h03, mtype, 8'h00, len};
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                reply_q.push_back(point);
            else if (i == 4)
                reply_q.push_back(contact);
            else
                reply_q.push_back(8'($urandom));
        end
        acc = 8'h00;
        foreach (reply_q[j])
            acc = acc + reply_q[j];
        reply_q.push_back(acc + sum_err);
    endtask

    task automatic make_status_reply(input logic [7:0] sum_err);
        logic [7:0] point;
        logic [7:0] contact;
        int         pick;
        point = ($urandom_range(9) == 0) ? 8'($urandom) : POINT_CONTACT;
        pick  = $urandom_range(9);
        if (pick < 4)
            contact = CONTACT_CLOSED;
        else if (pick < 8)
            contact = CONTACT_OPENED;
        else
            contact = 8'($urandom);
        make_reply(TYPE_STATUS, STATUS_LEN, point, contact, sum_err);
    endtask

    task automatic add_trailing_bytes();
        int n;
        if ($urandom_range(4) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) reply_q.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        int frame_no;
        int pick;
        int keep;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty reply, closed, opened, shortest long-press frame
        send_item(KIND_END, 8'hFF);
        make_reply(TYPE_STATUS, STATUS_LEN, POINT_CONTACT, CONTACT_CLOSED, 8'h00);
        send_reply();
        make_reply(TYPE_STATUS, STATUS_LEN, POINT_CONTACT, CONTACT_OPENED, 8'h00);
        send_reply();
        make_reply(TYPE_LONG_PRESS, 8'h00, 8'h00, 8'h00, 8'h00);
        send_reply();

        frame_no = 0;
        while (sent < ITEM_TARGET)
        begin
            frame_no++;
            quiet <= (frame_no >= 20 && frame_no < 32);
            if (frame_no == 45)
                hold_go <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                make_status_reply(8'h00);
                add_trailing_bytes();
            end
            else if (pick < 55)
            begin
                make_reply(TYPE_LONG_PRESS, 8'($urandom_range(0, 9)), 8'($urandom),
                           8'($urandom), 8'h00);
                add_trailing_bytes();
            end
            else if (pick < 65)
            begin
                make_reply(8'($urandom), 8'($urandom_range(0, 9)), 8'($urandom),
                           8'($urandom), 8'h00);
                add_trailing_bytes();
            end
            else if (pick < 75)
                make_status_reply(8'($urandom_range(1, 255)));
            else if (pick < 83)
            begin
                // cut short, possibly down to an empty reply
                make_status_reply(8'h00);
                keep = $urandom_range(0, reply_q.size() - 1);
                while (reply_q.size() > keep)
                    void'(reply_q.pop_back());
            end
            else if (pick < 91)
            begin
                // checksum lies beyond the capture limit
                make_reply(($urandom_range(1) != 0) ? TYPE_STATUS : TYPE_LONG_PRESS,
                           8'($urandom_range(10, 255)), 8'($urandom), 8'($urandom),
                           8'h00);
                keep = $urandom_range(7, 20);
                while (reply_q.size() > keep)
                    void'(reply_q.pop_back());
            end
            else
            begin
                reply_q.delete();
                keep = $urandom_range(1, 20);
                repeat (keep) reply_q.push_back(8'($urandom));
            end
            send_reply();
        end
        in_valid <= 1'b0;
        quiet    <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("PASS serial_mcu_reply_status_parser_top");
        else
            $display("FAIL serial_mcu_reply_status_parser_top");
        $finish;
    end

endmodule
